/* src/rtp_receive_statistics_unit_defines.svh */
// Assertion macros for the RTP receive statistics modules, used by rtps_back.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef RTP_RECEIVE_STATISTICS_UNIT_DEFINES_SVH
`define RTP_RECEIVE_STATISTICS_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RTPS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtps assertion failed");

// Next-cycle implication, checked outside reset.
`define RTPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtps assertion failed");

`endif

/* src/rtps_pkg.sv */
// Package for the RTP receive statistics unit: widths, constants and types.
// Used by every module of the block; depends on nothing.
package rtps_pkg;

    // Field widths.
    localparam int SEQ_W      = 16;
    localparam int TS_W       = 32;
    localparam int CLK_W      = 20;
    localparam int LIMIT_W    = 23;
    localparam int FRAC_W     = 8;
    localparam int CUM_W      = 23;
    localparam int JIT_W      = 23;
    localparam int CNT_W      = 32;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 88;

    // Request queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Fraction divider step count.
    localparam int DIV_STEPS = 8;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Constants of the statistics.
    localparam int CLOCK_RATE_RESET_HZ = 90000;
    localparam int JUMP_SECONDS        = 5;
    localparam logic [CLK_W-1:0]   CLOCK_RATE_RESET = CLK_W'(CLOCK_RATE_RESET_HZ);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(CLOCK_RATE_RESET_HZ * JUMP_SECONDS);
    localparam logic [LIMIT_W-1:0] JUMP_FACTOR = LIMIT_W'(JUMP_SECONDS);
    localparam logic [CUM_W-1:0]   CUM_LOST_MAX  = 23'h7FFFFF;
    localparam logic [FRAC_W-1:0]  FRACTION_FULL = 8'd255;
    localparam logic [3:0]         Q4_HALF       = 4'd8;

    typedef enum logic
    {
        OP_PACKET = 1'b0,
        OP_REPORT = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t              op;
        logic [SEQ_W-1:0] seq;
        logic [TS_W-1:0]  ts;
        logic [TS_W-1:0]  arrival;
    } item_t;

    typedef struct packed
    {
        logic  valid;
        item_t item;
    } queue_out_t;

    typedef struct packed
    {
        logic             start;
        logic [CNT_W-2:0] lost;
        logic [CNT_W-1:0] expected;
    } div_req_t;

    typedef struct packed
    {
        logic              busy;
        logic              done;
        logic [FRAC_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_JITTER,
        ST_DIV
    } back_state_t;

endpackage

/* src/rtps_front.sv */
// Front part: accepts stream requests, classifies them and queues them.
// Depends on rtps_pkg.
module rtps_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata fields from bit 0: sequence, rtp_timestamp, arrival_time
    input  logic [rtps_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tuser fields from bit 0: operation
    input  logic [0:0]                       s_axis_tuser,
    input  logic                             pop,
    output rtps_pkg::queue_out_t             head
);

    rtps_pkg::item_t                  mem_reg [rtps_pkg::QUEUE_DEPTH];
    logic [rtps_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [rtps_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [rtps_pkg::QCNT_W-1:0]      count_reg, count_next;
    rtps_pkg::item_t                  in_item;
    logic                             push;

    // Classify the incoming request.
    always_comb
    begin
        in_item.op      = rtps_pkg::op_t'(s_axis_tuser[0]);
        in_item.seq     = s_axis_tdata[15:0];
        in_item.ts      = s_axis_tdata[47:16];
        in_item.arrival = s_axis_tdata[79:48];
    end

    assign s_axis_tready = (count_reg != rtps_pkg::QCNT_W'(rtps_pkg::QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == rtps_pkg::QPTR_W'(rtps_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == rtps_pkg::QPTR_W'(rtps_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = mem_reg[rd_ptr_reg];

endmodule

/* src/rtps_frac_div.sv */
// Iterative divider for the report fraction: floor(255 * lost / expected).
// One quotient bit per cycle, valid only when lost < expected. Depends on rtps_pkg.
module rtps_frac_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  rtps_pkg::div_req_t req,
    output rtps_pkg::div_rsp_t rsp
);

    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [rtps_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [rtps_pkg::CNT_W-1:0]         rem_reg, rem_next;
    logic [rtps_pkg::CNT_W-1:0]         div_reg, div_next;
    logic [rtps_pkg::FRAC_W-1:0]        low_reg, low_next;
    logic [rtps_pkg::FRAC_W-1:0]        quo_reg, quo_next;
    logic [rtps_pkg::CNT_W+6:0]         num;
    logic [rtps_pkg::CNT_W:0]           trial;
    logic [rtps_pkg::CNT_W:0]           diff;
    logic                               fits;

    // Dividend is 255 * lost, formed as lost * 256 - lost.
    assign num   = {req.lost, 8'b0} - {8'b0, req.lost};
    assign trial = {rem_reg, low_reg[rtps_pkg::FRAC_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = !diff[rtps_pkg::CNT_W];

    // Restoring division step or load of a new request.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = {1'b0, num[rtps_pkg::CNT_W+6:8]};
            low_next  = num[7:0];
            div_next  = req.expected;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[rtps_pkg::CNT_W-1:0] : trial[rtps_pkg::CNT_W-1:0];
            low_next = {low_reg[rtps_pkg::FRAC_W-2:0], 1'b0};
            quo_next = {quo_reg[rtps_pkg::FRAC_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == rtps_pkg::DIV_CNT_W'(rtps_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

/* src/rtps_back.sv */
// Back part: sequence, loss and jitter state, report generation and output register.
// Depends on rtps_pkg (which holds the divider request and response structs) and the defines header.
`include "rtp_receive_statistics_unit_defines.svh"

module rtps_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  rtps_pkg::queue_out_t              head,
    output logic                              pop,
    input  logic [rtps_pkg::LIMIT_W-1:0]      limit,
    output rtps_pkg::div_req_t                div_req,
    input  rtps_pkg::div_rsp_t                div_rsp,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata fields from bit 0: loss_fraction, total_loss, highest_sequence, jitter
    output logic [rtps_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    rtps_pkg::back_state_t            state_reg, state_next;
    logic                             seen_reg, seen_next;
    logic [rtps_pkg::CNT_W-1:0]       ext_reg, ext_next;
    logic [rtps_pkg::CNT_W-1:0]       rep_high_reg, rep_high_next;
    logic [rtps_pkg::CNT_W-1:0]       loss_reg, loss_next;
    logic [rtps_pkg::CNT_W-1:0]       rep_loss_reg, rep_loss_next;
    logic [rtps_pkg::CNT_W-1:0]       offset_reg, offset_next;
    logic [rtps_pkg::CNT_W-1:0]       jitter_reg, jitter_next;
    logic [rtps_pkg::TS_W-1:0]        prev_ts_reg, prev_ts_next;
    logic [rtps_pkg::TS_W-1:0]        prev_arr_reg, prev_arr_next;
    logic [rtps_pkg::LIMIT_W-1:0]     mag_reg, mag_next;
    logic                             jit_go_reg, jit_go_next;
    logic                             out_valid_reg, out_valid_next;
    logic [rtps_pkg::FRAC_W-1:0]      frac_reg, frac_next;
    logic [rtps_pkg::CUM_W-1:0]       cum_reg, cum_next;
    logic [rtps_pkg::CNT_W-1:0]       high_out_reg, high_out_next;
    logic [rtps_pkg::JIT_W-1:0]       jit_out_reg, jit_out_next;

    logic [rtps_pkg::SEQ_W-1:0]       d16;
    logic                             advance;
    logic [rtps_pkg::TS_W-1:0]        raw;
    logic [rtps_pkg::TS_W-1:0]        mag32;
    logic                             mag_ok;
    logic                             ts_new;
    logic [rtps_pkg::CNT_W-1:0]       expected;
    logic [rtps_pkg::CNT_W-1:0]       lost;
    logic                             exp_pos;
    logic                             lost_pos;
    logic [rtps_pkg::CNT_W:0]         total;
    logic signed [33:0]               jit_sum;
    logic signed [33:0]               jit_new;

    // Sequence gap and transit difference of the request at the queue head.
    assign d16     = head.item.seq - ext_reg[rtps_pkg::SEQ_W-1:0];
    assign advance = (d16 != '0) && !d16[rtps_pkg::SEQ_W-1];
    assign raw     = (head.item.arrival - prev_arr_reg) - (head.item.ts - prev_ts_reg);
    assign mag32   = raw[rtps_pkg::TS_W-1] ? (~raw + 1'b1) : raw;
    assign mag_ok  = (mag32 < {9'b0, limit});
    assign ts_new  = (head.item.ts != prev_ts_reg);

    // Report interval values and the cumulative total.
    assign expected = ext_reg - rep_high_reg;
    assign lost     = loss_reg - rep_loss_reg;
    assign exp_pos  = !expected[rtps_pkg::CNT_W-1] && (expected != '0);
    assign lost_pos = !lost[rtps_pkg::CNT_W-1] && (lost != '0);
    assign total    = {loss_reg[rtps_pkg::CNT_W-1], loss_reg}
                    + {offset_reg[rtps_pkg::CNT_W-1], offset_reg};

    // Jitter update J += floor((16*|D| - J + 8) / 16), clamped at zero.
    assign jit_sum = $signed({7'b0, mag_reg, 4'b0}) - $signed({2'b0, jitter_reg})
                   + $signed({30'b0, rtps_pkg::Q4_HALF});
    assign jit_new = $signed({2'b0, jitter_reg}) + (jit_sum >>> 4);

    // Sequencer for packets and reports.
    always_comb
    begin
        state_next     = state_reg;
        seen_next      = seen_reg;
        ext_next       = ext_reg;
        rep_high_next  = rep_high_reg;
        loss_next      = loss_reg;
        rep_loss_next  = rep_loss_reg;
        offset_next    = offset_reg;
        jitter_next    = jitter_reg;
        prev_ts_next   = prev_ts_reg;
        prev_arr_next  = prev_arr_reg;
        mag_next       = mag_reg;
        jit_go_next    = jit_go_reg;
        frac_next      = frac_reg;
        cum_next       = cum_reg;
        high_out_next  = high_out_reg;
        jit_out_next   = jit_out_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        pop            = 1'b0;
        div_req        = '0;

        case (state_reg)
            rtps_pkg::ST_IDLE:
            begin
                if (head.valid && (head.item.op == rtps_pkg::OP_PACKET))
                begin
                    pop           = 1'b1;
                    prev_ts_next  = head.item.ts;
                    prev_arr_next = head.item.arrival;
                    if (!seen_reg)
                    begin
                        // The first packet only seeds the state.
                        seen_next     = 1'b1;
                        ext_next      = {16'b0, head.item.seq};
                        rep_high_next = {16'b0, head.item.seq} - 1'b1;
                    end
                    else
                    begin
                        if (advance)
                        begin
                            ext_next  = ext_reg + {16'b0, d16};
                            loss_next = loss_reg + {16'b0, d16} - 1'b1;
                        end
                        else
                        begin
                            loss_next = loss_reg - 1'b1;
                        end
                        mag_next    = mag32[rtps_pkg::LIMIT_W-1:0];
                        jit_go_next = ts_new && mag_ok;
                        state_next  = rtps_pkg::ST_JITTER;
                    end
                end
                else if (head.valid && !out_valid_reg)
                begin
                    pop           = 1'b1;
                    high_out_next = ext_reg;
                    jit_out_next  = jitter_reg[rtps_pkg::JIT_W+3:4];
                    rep_high_next = ext_reg;
                    rep_loss_next = loss_reg;
                    // Clamp the cumulative loss and remember a negative clamp.
                    if (total[rtps_pkg::CNT_W])
                    begin
                        cum_next    = '0;
                        offset_next = '0 - loss_reg;
                    end
                    else if (total[rtps_pkg::CNT_W-1:rtps_pkg::CUM_W] != '0)
                    begin
                        cum_next = rtps_pkg::CUM_LOST_MAX;
                    end
                    else
                    begin
                        cum_next = total[rtps_pkg::CUM_W-1:0];
                    end
                    // Fraction lost: saturated, zero, or from the divider.
                    if (exp_pos && lost_pos)
                    begin
                        if (lost >= expected)
                        begin
                            frac_next      = rtps_pkg::FRACTION_FULL;
                            out_valid_next = 1'b1;
                        end
                        else
                        begin
                            div_req.start    = 1'b1;
                            div_req.lost     = lost[rtps_pkg::CNT_W-2:0];
                            div_req.expected = expected;
                            state_next       = rtps_pkg::ST_DIV;
                        end
                    end
                    else
                    begin
                        frac_next      = '0;
                        out_valid_next = 1'b1;
                    end
                end
            end

            rtps_pkg::ST_JITTER:
            begin
                if (jit_go_reg)
                begin
                    jitter_next = jit_new[33] ? '0 : jit_new[rtps_pkg::CNT_W-1:0];
                end
                state_next = rtps_pkg::ST_IDLE;
            end

            rtps_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    frac_next      = div_rsp.quotient;
                    out_valid_next = 1'b1;
                    state_next     = rtps_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rtps_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and statistics state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rtps_pkg::ST_IDLE;
            seen_reg      <= 1'b0;
            ext_reg       <= '0;
            rep_high_reg  <= '0;
            loss_reg      <= '0;
            rep_loss_reg  <= '0;
            offset_reg    <= '0;
            jitter_reg    <= '0;
            prev_ts_reg   <= '0;
            prev_arr_reg  <= '0;
            jit_go_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            ext_reg       <= ext_next;
            rep_high_reg  <= rep_high_next;
            loss_reg      <= loss_next;
            rep_loss_reg  <= rep_loss_next;
            offset_reg    <= offset_next;
            jitter_reg    <= jitter_next;
            prev_ts_reg   <= prev_ts_next;
            prev_arr_reg  <= prev_arr_next;
            jit_go_reg    <= jit_go_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        frac_reg     <= frac_next;
        cum_reg      <= cum_next;
        high_out_reg <= high_out_next;
        jit_out_reg  <= jit_out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b0, jit_out_reg, high_out_reg, cum_reg, frac_reg};

    // The divider only runs while the sequencer waits for it.
    `RTPS_ASSERT_IMPL(a_div_busy_in_div, div_rsp.busy, state_reg == rtps_pkg::ST_DIV)
    // Requests leave the queue only from the idle state.
    `RTPS_ASSERT_IMPL(a_pop_from_idle, pop, (state_reg == rtps_pkg::ST_IDLE) && head.valid)
    // A pending division means the output register is free.
    `RTPS_ASSERT_IMPL(a_div_out_free, state_reg == rtps_pkg::ST_DIV, !out_valid_reg)
    // The jitter step is always followed by the idle state.
    `RTPS_ASSERT_NEXT(a_jitter_one_cycle, state_reg == rtps_pkg::ST_JITTER,
                      state_reg == rtps_pkg::ST_IDLE)

endmodule

/* src/rtp_receive_statistics_unit.sv */
// Top level of the RTP receive statistics unit: clock rate register and jump limit.
// Depends on rtps_pkg, rtps_front, rtps_frac_div and rtps_back.
//
//  Channel   Signals                          Content
//  cfg       cfg_wen, cfg_wdata[19:0]         clock_rate_hz
//  s_axis    tvalid, tready, tdata, tuser     packet or report request
//  m_axis    tvalid, tready, tdata            report values
//
// In the back part a packet gets gap, loss and transit difference in the idle state and
// the jitter update in the jitter state; the first packet only seeds the state. A report
// uses the idle state, and the divide state if the fraction needs the 8-step divider. A
// 2-entry queue lets the front accept while the back works, and packets keep flowing
// while a report waits in the output register. Reset clears all control and statistics
// state at once; no clearing pass. A cfg write goes to clock_rate_reg, then to limit_reg.
module rtp_receive_statistics_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wen,
    input  logic [rtps_pkg::CLK_W-1:0]       cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata fields from bit 0: sequence, rtp_timestamp, arrival_time
    input  logic [rtps_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tuser fields from bit 0: operation
    input  logic [0:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata fields from bit 0: loss_fraction, total_loss, highest_sequence, jitter
    output logic [rtps_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    logic [rtps_pkg::CLK_W-1:0]    clock_rate_reg, clock_rate_next;
    logic [rtps_pkg::LIMIT_W-1:0]  limit_reg, limit_next;
    rtps_pkg::queue_out_t          head;
    logic                          pop;
    rtps_pkg::div_req_t            div_req;
    rtps_pkg::div_rsp_t            div_rsp;

    // Clock rate register and the five-second jump limit derived from it.
    assign clock_rate_next = cfg_wen ? cfg_wdata : clock_rate_reg;
    assign limit_next      = {3'b0, clock_rate_reg} * rtps_pkg::JUMP_FACTOR;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_rate_reg <= rtps_pkg::CLOCK_RATE_RESET;
            limit_reg      <= rtps_pkg::LIMIT_RESET;
        end
        else
        begin
            clock_rate_reg <= clock_rate_next;
            limit_reg      <= limit_next;
        end
    end

    rtps_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .pop           (pop),
        .head          (head)
    );

    rtps_frac_div u_frac_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    rtps_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .limit         (limit_reg),
        .div_req       (div_req),
        .div_rsp       (div_rsp),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
